/* rtl/core/tsct_pkg.sv */
// Shared constants for the Taylor sine/cosine/tangent core: stream widths,
// opcode and status codes, fixed-point limits. No dependencies.
package tsct_pkg;

  localparam int unsigned LAST_POWER_DEF = 100;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 40;

  // opcodes
  localparam logic [1:0] OP_SIN  = 2'd0;
  localparam logic [1:0] OP_COS  = 2'd1;
  localparam logic [1:0] OP_TAN  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZDIV = 2'd2;

  // fixed-point limits (Q40 internal format)
  localparam logic [63:0] ONE_Q40  = 64'd1 << 40;
  localparam logic [63:0] TERM_CAP = 64'd1 << 56;
  localparam logic [40:0] QUOT_CAP = 41'd1 << 40;

  localparam int unsigned RECIP_W = 40;

endpackage

/* rtl/core/taylor_sine_cosine_tangent_core.sv */
// Taylor-series sine, cosine and tangent of a Q3.28 angle, result in Q8.24.
// Depends on tsct_pkg. One shared 32x32 multiplier, four partial products per multiply.
// At LAST_POWER 100 the sine series sums odd powers 1 to 99, the cosine series even
// powers 0 to 100; tangent runs both series and a 128-step restoring divide. Each
// term after the first costs two multiplies plus one accumulate. One item at a time:
// a new item is taken once the last result is in the output register; async reset idles.
module taylor_sine_cosine_tangent_core #(
  parameter int unsigned LAST_POWER = tsct_pkg::LAST_POWER_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [1:0] opcode, [33:2] angle, [39:34] zero
  input  logic [tsct_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [31:0] value, [33:32] status, [39:34] zero
  output logic [tsct_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned ROM_DEPTH = LAST_POWER - 1;
  localparam int unsigned KW        = $clog2(ROM_DEPTH);
  localparam logic [KW:0] K_LAST    = (KW+1)'(LAST_POWER - 2);
  localparam logic [2:0]  MUL_LAST  = 3'd4;
  localparam logic [6:0]  DIV_LAST  = 7'd127;
  localparam logic [127:0] HALF_SQ  = 128'd1 << 15;
  localparam logic [127:0] HALF_Q40 = 128'd1 << 39;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_M1, ST_M2, ST_ACC, ST_ABS, ST_DSET, ST_DIV, ST_RND, ST_OUT
  } state_e;

  // reciprocal table: round(2^40 / ((k+1)(k+2)))
  wire [tsct_pkg::RECIP_W-1:0] recip_rom [ROM_DEPTH];
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [63:0] DEN   = 64'((g + 1) * (g + 2));
    localparam logic [63:0] RECIP = ((64'd1 << 40) + DEN / 64'd2) / DEN;
    assign recip_rom[g] = RECIP[tsct_pkg::RECIP_W-1:0];
  end

  state_e state_q, state_d;
  logic [2:0]   mul_cnt_q, mul_cnt_d;
  logic [6:0]   div_cnt_q, div_cnt_d;
  logic         m_tvalid_q, m_tvalid_d;
  logic [tsct_pkg::OUT_W-1:0] m_tdata_q, m_tdata_d;

  logic [1:0]   op_q, op_d;
  logic         xneg_q, xneg_d;
  logic [31:0]  ax_q, ax_d;
  logic [46:0]  x2_q, x2_d;
  logic [62:0]  term_q, term_d;
  logic [tsct_pkg::RECIP_W-1:0] recip_q, recip_d;
  logic [KW-1:0] k_q, k_d;
  logic         tneg_q, tneg_d;
  logic         odd_q, odd_d;
  logic [63:0]  acc_q, acc_d;
  logic [63:0]  s_q, s_d;
  logic         sneg_q, sneg_d;
  logic         cneg_q, cneg_d;
  logic [63:0]  mc_q, mc_d;
  logic [127:0] num_q, num_d;
  logic [63:0]  r_q, r_d;
  logic [40:0]  quo_q, quo_d;
  logic [48:0]  mag_q, mag_d;
  logic         oneg_q, oneg_d;
  logic         zdiv_q, zdiv_d;
  logic [63:0]  pp_q, pp_d;
  logic [127:0] prod_q, prod_d;

  // input fields
  logic [1:0]  in_op;
  logic [31:0] in_ang, in_abs;
  assign in_op  = s_axis_tdata_i[1:0];
  assign in_ang = s_axis_tdata_i[33:2];
  assign in_abs = in_ang[31] ? (32'd0 - in_ang) : in_ang;

  // shared multiplier: operand select, one 32x32 partial product per cycle
  logic [63:0]  mul_a, mul_b;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh, prod_sum;
  logic [63:0]  mul_res;
  logic [56:0]  term_cap;

  always_comb begin
    case (state_q)
      ST_SQ: begin
        mul_a = {32'd0, ax_q};
        mul_b = {32'd0, ax_q};
      end
      ST_M2: begin
        mul_a = {1'b0, term_q};
        mul_b = {24'd0, recip_q};
      end
      default: begin
        mul_a = {1'b0, term_q};
        mul_b = {17'd0, x2_q};
      end
    endcase
  end

  assign a_half = mul_cnt_q[0] ? mul_a[63:32] : mul_a[31:0];
  assign b_half = mul_cnt_q[1] ? mul_b[63:32] : mul_b[31:0];
  assign pp     = a_half * b_half;

  // partial product registered last cycle, aligned by its half positions
  always_comb begin
    case (mul_cnt_q)
      3'd1:    pp_sh = {64'd0, pp_q};
      3'd2,
      3'd3:    pp_sh = {32'd0, pp_q, 32'd0};
      3'd4:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = '0;
    endcase
  end

  assign prod_sum = prod_q + pp_sh;
  // rounding half was preloaded into the product register
  assign mul_res  = (state_q == ST_SQ) ? prod_sum[79:16] : prod_sum[103:40];
  assign term_cap = (mul_res > tsct_pkg::TERM_CAP) ? tsct_pkg::TERM_CAP[56:0] : mul_res[56:0];

  // series accumulate: sign flips every term
  logic [63:0] sterm, acc_next;
  logic [KW:0] next_k;
  logic        k_more;
  assign sterm    = {7'd0, term_q[56:0]};
  assign acc_next = tneg_q ? (acc_q + sterm) : (acc_q - sterm);
  assign next_k   = {1'b0, k_q} + (KW+1)'(2);
  assign k_more   = (next_k <= K_LAST);

  // series start values
  logic [63:0] ax40;
  assign ax40 = {20'd0, ax_q, 12'd0};

  // sin/cos rounding Q40 -> Q24 on the magnitude, one adder
  logic [64:0] rnd_sum;
  assign rnd_sum = {1'b0, (acc_q[63] ? ~acc_q : acc_q)}
                 + (acc_q[63] ? 65'h8001 : 65'h8000);

  // tangent divide step
  logic [127:0] dividend;
  logic [64:0]  r_sh, r_sub;
  logic         r_ge;
  logic [40:0]  quo_sh, quo_next;
  assign dividend = {40'd0, s_q, 24'd0} + {65'd0, mc_q[63:1]};
  assign r_sh     = {r_q, num_q[127]};
  assign r_ge     = (r_sh >= {1'b0, mc_q});
  assign r_sub    = r_sh - {1'b0, mc_q};
  assign quo_sh   = (quo_q >= tsct_pkg::QUOT_CAP) ? tsct_pkg::QUOT_CAP : {quo_q[39:0], 1'b0};
  assign quo_next = (r_ge && (quo_sh < tsct_pkg::QUOT_CAP)) ? (quo_sh | 41'd1) : quo_sh;

  // saturate to Q8.24
  logic [31:0] emit_val;
  logic [1:0]  emit_st;
  always_comb begin
    emit_val = mag_q[31:0];
    emit_st  = tsct_pkg::STAT_OK;
    if (zdiv_q) begin
      emit_val = '0;
      emit_st  = tsct_pkg::STAT_ZDIV;
    end else if (oneg_q) begin
      if (mag_q > 49'h0_8000_0000) begin
        emit_val = 32'h8000_0000;
        emit_st  = tsct_pkg::STAT_SAT;
      end else begin
        emit_val = 32'd0 - mag_q[31:0];
      end
    end else if (mag_q > 49'h0_7FFF_FFFF) begin
      emit_val = 32'h7FFF_FFFF;
      emit_st  = tsct_pkg::STAT_SAT;
    end
  end

  logic start_ser, start_cos;

  always_comb begin
    state_d    = state_q;
    mul_cnt_d  = mul_cnt_q;
    div_cnt_d  = div_cnt_q;
    m_tvalid_d = m_tvalid_q & ~m_axis_tready_i;
    m_tdata_d  = m_tdata_q;
    op_d       = op_q;
    xneg_d     = xneg_q;
    ax_d       = ax_q;
    x2_d       = x2_q;
    term_d     = term_q;
    recip_d    = recip_q;
    k_d        = k_q;
    tneg_d     = tneg_q;
    odd_d      = odd_q;
    acc_d      = acc_q;
    s_d        = s_q;
    sneg_d     = sneg_q;
    cneg_d     = cneg_q;
    mc_d       = mc_q;
    num_d      = num_q;
    r_d        = r_q;
    quo_d      = quo_q;
    mag_d      = mag_q;
    oneg_d     = oneg_q;
    zdiv_d     = zdiv_q;
    pp_d       = pp_q;
    prod_d     = prod_q;
    start_ser  = 1'b0;
    start_cos  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d      = in_op;
          xneg_d    = in_ang[31];
          ax_d      = in_abs;
          zdiv_d    = 1'b0;
          mul_cnt_d = '0;
          if (in_op == tsct_pkg::OP_NONE) begin
            mag_d   = '0;
            oneg_d  = 1'b0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ, ST_M1, ST_M2: begin
        pp_d      = pp;
        prod_d    = (mul_cnt_q == 3'd0) ? ((state_q == ST_SQ) ? HALF_SQ : HALF_Q40) : prod_sum;
        mul_cnt_d = mul_cnt_q + 3'd1;
        if (mul_cnt_q == MUL_LAST) begin
          mul_cnt_d = '0;
          case (state_q)
            ST_SQ: begin
              x2_d      = mul_res[46:0];
              start_ser = 1'b1;
              start_cos = (op_q == tsct_pkg::OP_COS);
              state_d   = ST_M1;
            end
            ST_M1: begin
              term_d  = mul_res[62:0];
              state_d = ST_M2;
            end
            default: begin
              term_d  = {6'd0, term_cap};
              state_d = ST_ACC;
            end
          endcase
        end
      end
      ST_ACC: begin
        tneg_d = ~tneg_q;
        acc_d  = acc_next;
        if (k_more) begin
          k_d     = next_k[KW-1:0];
          recip_d = recip_rom[next_k[KW-1:0]];
          state_d = ST_M1;
        end else if (op_q != tsct_pkg::OP_TAN) begin
          state_d = ST_RND;
        end else if (odd_q) begin
          // tangent: keep the sine sum, run the cosine series next
          s_d       = acc_next;
          start_ser = 1'b1;
          start_cos = 1'b1;
          state_d   = ST_M1;
        end else begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        sneg_d  = s_q[63];
        cneg_d  = acc_q[63];
        s_d     = s_q[63] ? (64'd0 - s_q) : s_q;
        mc_d    = acc_q[63] ? (64'd0 - acc_q) : acc_q;
        state_d = ST_DSET;
      end
      ST_DSET: begin
        if (mc_q == 64'd0) begin
          mag_d   = '0;
          oneg_d  = 1'b0;
          zdiv_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          num_d     = dividend;
          r_d       = '0;
          quo_d     = '0;
          div_cnt_d = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        num_d     = {num_q[126:0], 1'b0};
        r_d       = r_ge ? r_sub[63:0] : r_sh[63:0];
        quo_d     = quo_next;
        div_cnt_d = div_cnt_q + 7'd1;
        if (div_cnt_q == DIV_LAST) begin
          mag_d   = {8'd0, quo_next};
          oneg_d  = sneg_q ^ cneg_q;
          state_d = ST_OUT;
        end
      end
      ST_RND: begin
        mag_d   = rnd_sum[64:16];
        oneg_d  = acc_q[63];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!m_tvalid_q || m_axis_tready_i) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {6'd0, emit_st, emit_val};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_ser) begin
      odd_d = ~start_cos;
      if (start_cos) begin
        term_d  = tsct_pkg::ONE_Q40[62:0];
        tneg_d  = 1'b0;
        k_d     = KW'(0);
        recip_d = recip_rom[KW'(0)];
        acc_d   = tsct_pkg::ONE_Q40;
      end else begin
        term_d  = ax40[62:0];
        tneg_d  = xneg_q;
        k_d     = KW'(1);
        recip_d = recip_rom[KW'(1)];
        acc_d   = xneg_q ? (64'd0 - ax40) : ax40;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mul_cnt_q  <= '0;
      div_cnt_q  <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      state_q    <= state_d;
      mul_cnt_q  <= mul_cnt_d;
      div_cnt_q  <= div_cnt_d;
      m_tvalid_q <= m_tvalid_d;
      m_tdata_q  <= m_tdata_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    xneg_q  <= xneg_d;
    ax_q    <= ax_d;
    x2_q    <= x2_d;
    term_q  <= term_d;
    recip_q <= recip_d;
    k_q     <= k_d;
    tneg_q  <= tneg_d;
    odd_q   <= odd_d;
    acc_q   <= acc_d;
    s_q     <= s_d;
    sneg_q  <= sneg_d;
    cneg_q  <= cneg_d;
    mc_q    <= mc_d;
    num_q   <= num_d;
    r_q     <= r_d;
    quo_q   <= quo_d;
    mag_q   <= mag_d;
    oneg_q  <= oneg_d;
    zdiv_q  <= zdiv_d;
    pp_q    <= pp_d;
    prod_q  <= prod_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q != ST_IDLE))
    else $error("core still idle after accepting an item");

  a_term_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> ({1'b0, term_q} <= tsct_pkg::TERM_CAP))
    else $error("series term above cap at accumulate");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> ($past(state_q) == ST_OUT))
    else $error("output valid raised outside the output state");

  a_zdiv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && (m_tdata_q[33:32] == tsct_pkg::STAT_ZDIV)) |-> (m_tdata_q[31:0] == 32'd0))
    else $error("zero-cosine status with nonzero value");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (r_q < mc_q))
    else $error("divider remainder not below divisor");

endmodule
